// ===== rtl/core/adm_pkg.sv =====
// ---------------------------------------------------------------------------
// adm_pkg: shared types and constants of the arcade drive mixer
// Sideband struct carried down the pipeline, Q15 constants, and the
// elaboration-time builder of the turn shaping table.
// ---------------------------------------------------------------------------
`default_nettype none

package adm_pkg;

  // default address width of the shaping table
  localparam int SHAPE_TABLE_BITS_DEFAULT = 8;

  // Q15 values
  localparam logic [15:0] Q15_ONE = 16'd32768;
  localparam logic [14:0] SENS_RESET = 15'd26214;

  // 0.35*pi in Q30
  localparam logic [63:0] ANGLE_Q30 = 64'd1180640799;
  localparam int TAYLOR_TERMS = 8;

  // Taylor divisors (2n)(2n+1)
  localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

  // wheel select codes
  localparam logic [1:0] WHEEL_LEFT  = 2'd0;
  localparam logic [1:0] WHEEL_RIGHT = 2'd1;

  // sideband that travels with each sample
  typedef struct packed {
    logic              valid;
    logic signed [16:0] move;
    logic signed [16:0] turn;
    logic              rev;
    logic              quick;
    logic [1:0]        wheel;
  } side_t;

  // sine of a Q30 angle, Q30 result, truncating Taylor sum
  function automatic logic signed [63:0] sin_q30(input logic [63:0] y);
    logic [63:0]        term;
    logic signed [63:0] sum;
    term = y;
    sum  = signed'(y);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = (term * y) >> 30;
      term = (term * y) >> 30;
      term = term / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    return sum;
  endfunction

  localparam logic [63:0] SHAPE_FULL = unsigned'(sin_q30(ANGLE_Q30));

  // table entry k of a 2^bits table, Q15, entry 2^bits is +1.0
  function automatic logic [15:0] shape_entry(input int unsigned k, input int unsigned bits);
    logic [63:0]        y;
    logic signed [63:0] s;
    logic [63:0]        us;
    logic [63:0]        e;
    y  = (ANGLE_Q30 * 64'(k) + ((64'd1 << bits) >> 1)) >> bits;
    s  = sin_q30(y);
    us = (s < 0) ? 64'd0 : unsigned'(s);
    e  = (us * 64'd32768 + (SHAPE_FULL >> 1)) / SHAPE_FULL;
    return e[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/adm_shaper.sv =====
// ---------------------------------------------------------------------------
// adm_shaper: one registered pass of the turn shaping curve
// Table lookup on the magnitude with linear interpolation, sign restored.
// ---------------------------------------------------------------------------
`default_nettype none

module adm_shaper #(
  parameter int TABLE_BITS = adm_pkg::SHAPE_TABLE_BITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire adm_pkg::side_t     side_in,
  input  wire logic signed [16:0] x_in,
  output adm_pkg::side_t          side_out,
  output logic signed [16:0]      y_out
);

  localparam int SH    = 15 - TABLE_BITS;
  localparam int COUNT = 1 << TABLE_BITS;

  // constant table, one extra entry repeating +1.0
  logic [15:0] shape_rom [0:COUNT+1];
  for (genvar k = 0; k <= COUNT; k++) begin : g_rom
    assign shape_rom[k] = adm_pkg::shape_entry(k, TABLE_BITS);
  end
  assign shape_rom[COUNT+1] = adm_pkg::shape_entry(COUNT, TABLE_BITS);

  logic [16:0]         mag_raw;
  logic [15:0]         mag;
  logic [TABLE_BITS:0] idx_lo;
  logic [TABLE_BITS:0] idx_hi;
  logic [SH-1:0]       frac;
  logic [15:0]         lo;
  logic [15:0]         hi;
  logic [15+SH:0]      step;
  logic [15:0]         v;
  logic signed [16:0]  y_next;

  // magnitude, clamped to +1.0
  always_comb begin
    mag_raw = x_in[16] ? 17'(-x_in) : 17'(x_in);
    mag     = (mag_raw > {1'b0, adm_pkg::Q15_ONE}) ? adm_pkg::Q15_ONE : mag_raw[15:0];
  end

  // interpolate between neighboring entries, round half up
  always_comb begin
    idx_lo = mag[15:SH];
    idx_hi = idx_lo + 1'b1;
    frac   = mag[SH-1:0];
    lo     = shape_rom[idx_lo];
    hi     = shape_rom[idx_hi];
    step   = (16+SH)'(hi - lo) * (16+SH)'(frac) + (16+SH)'(1 << (SH - 1));
    v      = lo + step[15+SH:SH];
    y_next = x_in[16] ? -signed'({1'b0, v}) : signed'({1'b0, v});
  end

  // stage register
  always_ff @(posedge clk) begin
    y_out <= y_next;
    if (rst) begin
      side_out <= '0;
    end else begin
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/adm_mul.sv =====
// ---------------------------------------------------------------------------
// adm_mul: registered Q15 by Q15 multiply
// Sign-magnitude product rounded half away from zero back to Q15.
// ---------------------------------------------------------------------------
`default_nettype none

module adm_mul (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire adm_pkg::side_t     side_in,
  input  wire logic signed [16:0] a_in,
  input  wire logic signed [16:0] b_in,
  output adm_pkg::side_t          side_out,
  output logic signed [16:0]      p_out
);

  logic [16:0]        ma_raw;
  logic [16:0]        mb_raw;
  logic [31:0]        prod;
  logic [15:0]        pm;
  logic signed [16:0] p_next;

  // magnitudes fit 16 bits (at most +1.0)
  always_comb begin
    ma_raw = a_in[16] ? 17'(-a_in) : 17'(a_in);
    mb_raw = b_in[16] ? 17'(-b_in) : 17'(b_in);
    prod   = 32'(ma_raw[15:0]) * 32'(mb_raw[15:0]) + 32'(1 << 14);
    pm     = prod[30:15];
    p_next = (a_in[16] ^ b_in[16]) ? -signed'({1'b0, pm}) : signed'({1'b0, pm});
  end

  // stage register
  always_ff @(posedge clk) begin
    p_out <= p_next;
    if (rst) begin
      side_out <= '0;
    end else begin
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/adm_mix.sv =====
// ---------------------------------------------------------------------------
// adm_mix: left/right mixing, clipping with spill, wheel select
// Two register stages: side sums, then clip, select and saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module adm_mix (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire adm_pkg::side_t     side_in,
  input  wire logic signed [16:0] rot_in,
  output logic                    done,
  output logic signed [15:0]      motor_drive
);

  localparam logic signed [18:0] ONE_P = 19'sd32768;
  localparam logic signed [18:0] ONE_N = -19'sd32768;
  localparam logic signed [18:0] SAT_P = 19'sd32767;

  typedef struct packed {
    logic              valid;
    logic signed [18:0] left;
    logic signed [18:0] right;
    logic              quick;
    logic [1:0]        wheel;
  } sum_t;

  sum_t sums;

  // stage A: side sums
  always_ff @(posedge clk) begin
    sums.left  <= 19'(side_in.move) + 19'(rot_in);
    sums.right <= 19'(side_in.move) - 19'(rot_in);
    sums.quick <= side_in.quick;
    sums.wheel <= side_in.wheel;
    if (rst) begin
      sums.valid <= 1'b0;
    end else begin
      sums.valid <= side_in.valid;
    end
  end

  logic signed [18:0] left_c;
  logic signed [18:0] right_c;
  logic signed [18:0] sel;
  logic signed [15:0] drive_next;

  // clip the first side found out of range, spill excess in quick turn
  always_comb begin
    left_c  = sums.left;
    right_c = sums.right;
    if (sums.left > ONE_P) begin
      if (sums.quick) right_c = sums.right - (sums.left - ONE_P);
      left_c = ONE_P;
    end else if (sums.right > ONE_P) begin
      if (sums.quick) left_c = sums.left - (sums.right - ONE_P);
      right_c = ONE_P;
    end else if (sums.left < ONE_N) begin
      if (sums.quick) right_c = sums.right + (ONE_N - sums.left);
      left_c = ONE_N;
    end else if (sums.right < ONE_N) begin
      if (sums.quick) left_c = sums.left + (ONE_N - sums.right);
      right_c = ONE_N;
    end
  end

  // wheel select and saturation
  always_comb begin
    case (sums.wheel)
      adm_pkg::WHEEL_LEFT:  sel = left_c;
      adm_pkg::WHEEL_RIGHT: sel = right_c;
      default:              sel = '0;
    endcase
    if (sel > SAT_P) begin
      drive_next = 16'sd32767;
    end else if (sel < ONE_N) begin
      drive_next = 16'sh8000;
    end else begin
      drive_next = sel[15:0];
    end
  end

  // stage B: output register
  always_ff @(posedge clk) begin
    motor_drive <= drive_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sums.valid;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/arcade_drive_mixer.sv =====
// ---------------------------------------------------------------------------
// arcade_drive_mixer: joystick sample to one wheel drive
// Axis sign handling, double turn shaping, sensitivity scaling, mixing.
// ---------------------------------------------------------------------------
// Usage:
//   A sample (throttle_axis, turn_axis, reverse_drive, quick_turn, wheel)
//   transfers at a rising edge with start high and busy low. busy is always
//   low: a new sample can enter every cycle.
//   Each result appears on motor_drive for exactly one cycle with done high,
//   in sample order, after six register stages: shaping pass 1, shaping
//   pass 2, throttle*turn multiply, sensitivity multiply, side sums,
//   clip/select/saturate.
//   Throughput is one sample per cycle; the receiver cannot stall, so there
//   is no back pressure anywhere in the pipeline. turn_sensitivity is
//   written over the cfg channel (cfg_ready always high); the user must
//   write it only while no sample is in flight; the block does not
//   enforce this. It is used by the fourth stage. Reset (synchronous,
//   rst high) empties the pipeline and loads the sensitivity with 0.8. The
//   shaping table is a constant built at elaboration from SHAPE_TABLE_BITS.
// ---------------------------------------------------------------------------
`default_nettype none

module arcade_drive_mixer #(
  parameter int SHAPE_TABLE_BITS = adm_pkg::SHAPE_TABLE_BITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] throttle_axis,
  input  wire logic signed [15:0] turn_axis,
  input  wire logic               reverse_drive,
  input  wire logic               quick_turn,
  input  wire logic [1:0]         wheel,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [14:0]        cfg_data,
  output logic                    done,
  output logic signed [15:0]      motor_drive
);

  logic [14:0] turn_sensitivity;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // sensitivity register
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_sensitivity <= adm_pkg::SENS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      turn_sensitivity <= cfg_data;
    end
  end

  // input sign handling: forward on the stick is negative
  adm_pkg::side_t     side0;
  logic signed [16:0] thr;
  logic signed [16:0] trn;
  logic signed [16:0] rot0;

  always_comb begin
    thr         = 17'(throttle_axis);
    trn         = 17'(turn_axis);
    side0.valid = start && !busy;
    side0.move  = reverse_drive ? thr : -thr;
    side0.turn  = '0;
    side0.rev   = reverse_drive;
    side0.quick = quick_turn;
    side0.wheel = wheel;
    rot0        = reverse_drive ? -trn : trn;
  end

  // two shaping passes
  adm_pkg::side_t     side1;
  adm_pkg::side_t     side2;
  logic signed [16:0] rot1;
  logic signed [16:0] rot2;

  adm_shaper #(.TABLE_BITS(SHAPE_TABLE_BITS)) u_shape1 (
    .clk      (clk),
    .rst      (rst),
    .side_in  (side0),
    .x_in     (rot0),
    .side_out (side1),
    .y_out    (rot1)
  );

  adm_shaper #(.TABLE_BITS(SHAPE_TABLE_BITS)) u_shape2 (
    .clk      (clk),
    .rst      (rst),
    .side_in  (side1),
    .x_in     (rot1),
    .side_out (side2),
    .y_out    (rot2)
  );

  // quick-turn value rides along in the sideband
  adm_pkg::side_t side2q;
  always_comb begin
    side2q      = side2;
    side2q.turn = side2.rev ? -rot2 : rot2;
  end

  // throttle * turn, then * sensitivity
  adm_pkg::side_t     side3;
  adm_pkg::side_t     side4;
  logic signed [16:0] prod1;
  logic signed [16:0] prod2;

  adm_mul u_mul1 (
    .clk      (clk),
    .rst      (rst),
    .side_in  (side2q),
    .a_in     (side2.move),
    .b_in     (rot2),
    .side_out (side3),
    .p_out    (prod1)
  );

  adm_mul u_mul2 (
    .clk      (clk),
    .rst      (rst),
    .side_in  (side3),
    .a_in     (prod1),
    .b_in     (signed'({2'b00, turn_sensitivity})),
    .side_out (side4),
    .p_out    (prod2)
  );

  // pick the turn term and mix
  logic signed [16:0] rot_final;
  assign rot_final = side4.quick ? side4.turn : prod2;

  adm_mix u_mix (
    .clk         (clk),
    .rst         (rst),
    .side_in     (side4),
    .rot_in      (rot_final),
    .done        (done),
    .motor_drive (motor_drive)
  );

endmodule

`default_nettype wire
